/* rtl/caar_pkg.sv */
package caar_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned POS_W      = 4;
    localparam int unsigned CNT_W      = 5;
    localparam int unsigned CHECK_POS  = 9;
    localparam int unsigned OPA_LAST   = 4;
    localparam int unsigned RESP_BYTES = 13;
    localparam int unsigned RESP_W     = RESP_BYTES * BYTE_W;

    localparam logic [BYTE_W-1:0] OP_ADD = 8'd1;
    localparam logic [BYTE_W-1:0] OP_SUB = 8'd2;
    localparam logic [BYTE_W-1:0] OP_MUL = 8'd3;
    localparam logic [BYTE_W-1:0] OP_DIV = 8'd4;

    typedef struct packed {
        logic              start;
        logic [BYTE_W-1:0] op;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] result;
    } alu_rsp_t;

endpackage

/* rtl/caar_alu.sv */
// Iterative ALU around one shared 33-bit adder/subtractor.
// Add/sub: a single adder pass. Multiply: 32 shift-add steps. Divide: two magnitude steps,
// 32 restoring steps and one sign fix.
module caar_alu
(
    input  logic               clk,
    input  logic               rst_n,
    input  caar_pkg::alu_req_t req,
    output caar_pkg::alu_rsp_t rsp
);

    typedef enum logic [2:0] {
        A_IDLE,
        A_MUL,
        A_NEGA,
        A_NEGB,
        A_DIV,
        A_FIX
    } alu_state_t;

    alu_state_t                       state_reg;
    logic [caar_pkg::CNT_W-1:0]       cnt_reg;
    logic [caar_pkg::WORD_W-1:0]      acc_reg;     // product / remainder
    logic [caar_pkg::WORD_W-1:0]      mcand_reg;   // multiplicand / divisor
    logic [caar_pkg::WORD_W-1:0]      shift_reg;   // multiplier / dividend-quotient
    logic                             neg_q_reg;
    logic                             done_reg;
    logic [caar_pkg::WORD_W-1:0]      result_reg;

    logic [caar_pkg::WORD_W:0]        add_x;
    logic [caar_pkg::WORD_W:0]        add_y;
    logic                             add_sub;
    logic [caar_pkg::WORD_W+1:0]      add_sum;

    // Shared adder operand selection
    always_comb
    begin
        add_x   = '0;
        add_y   = '0;
        add_sub = 1'b0;
        case (state_reg)
            A_IDLE:
            begin
                add_x   = {1'b0, req.a};
                add_y   = {1'b0, req.b};
                add_sub = (req.op == caar_pkg::OP_SUB);
            end
            A_MUL:
            begin
                add_x = {1'b0, acc_reg};
                add_y = shift_reg[0] ? {1'b0, mcand_reg} : '0;
            end
            A_NEGA:
            begin
                add_y   = {1'b0, shift_reg};
                add_sub = 1'b1;
            end
            A_NEGB:
            begin
                add_y   = {1'b0, mcand_reg};
                add_sub = 1'b1;
            end
            A_DIV:
            begin
                add_x   = {acc_reg, shift_reg[caar_pkg::WORD_W-1]};
                add_y   = {1'b0, mcand_reg};
                add_sub = 1'b1;
            end
            A_FIX:
            begin
                add_y   = {1'b0, shift_reg};
                add_sub = 1'b1;
            end
            default:
            begin
                add_sub = 1'b0;
            end
        endcase
    end

    assign add_sum = add_sub ? ({1'b0, add_x} - {1'b0, add_y})
                             : ({1'b0, add_x} + {1'b0, add_y});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= A_IDLE;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
            acc_reg    <= '0;
            mcand_reg  <= '0;
            shift_reg  <= '0;
            neg_q_reg  <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                A_IDLE:
                begin
                    if (req.start)
                    begin
                        cnt_reg <= '1;
                        acc_reg <= '0;
                        case (req.op)
                            caar_pkg::OP_ADD,
                            caar_pkg::OP_SUB:
                            begin
                                result_reg <= add_sum[caar_pkg::WORD_W-1:0];
                                done_reg   <= 1'b1;
                            end
                            caar_pkg::OP_MUL:
                            begin
                                mcand_reg <= req.a;
                                shift_reg <= req.b;
                                state_reg <= A_MUL;
                            end
                            caar_pkg::OP_DIV:
                            begin
                                if (req.b == '0)
                                begin
                                    result_reg <= '0;
                                    done_reg   <= 1'b1;
                                end
                                else
                                begin
                                    shift_reg <= req.a;
                                    mcand_reg <= req.b;
                                    neg_q_reg <= req.a[caar_pkg::WORD_W-1]
                                               ^ req.b[caar_pkg::WORD_W-1];
                                    state_reg <= A_NEGA;
                                end
                            end
                            default:
                            begin
                                result_reg <= '0;
                                done_reg   <= 1'b1;
                            end
                        endcase
                    end
                end
                A_MUL:
                begin
                    acc_reg   <= add_sum[caar_pkg::WORD_W-1:0];
                    mcand_reg <= {mcand_reg[caar_pkg::WORD_W-2:0], 1'b0};
                    shift_reg <= {1'b0, shift_reg[caar_pkg::WORD_W-1:1]};
                    cnt_reg   <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                    begin
                        result_reg <= add_sum[caar_pkg::WORD_W-1:0];
                        done_reg   <= 1'b1;
                        state_reg  <= A_IDLE;
                    end
                end
                A_NEGA:
                begin
                    // Take the dividend magnitude
                    if (shift_reg[caar_pkg::WORD_W-1])
                    begin
                        shift_reg <= add_sum[caar_pkg::WORD_W-1:0];
                    end
                    state_reg <= A_NEGB;
                end
                A_NEGB:
                begin
                    // Take the divisor magnitude
                    if (mcand_reg[caar_pkg::WORD_W-1])
                    begin
                        mcand_reg <= add_sum[caar_pkg::WORD_W-1:0];
                    end
                    state_reg <= A_DIV;
                end
                A_DIV:
                begin
                    // Restoring step: keep the difference when it did not borrow
                    if (!add_sum[caar_pkg::WORD_W+1])
                    begin
                        acc_reg   <= add_sum[caar_pkg::WORD_W-1:0];
                        shift_reg <= {shift_reg[caar_pkg::WORD_W-2:0], 1'b1};
                    end
                    else
                    begin
                        acc_reg   <= add_x[caar_pkg::WORD_W-1:0];
                        shift_reg <= {shift_reg[caar_pkg::WORD_W-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                    begin
                        state_reg <= A_FIX;
                    end
                end
                A_FIX:
                begin
                    result_reg <= neg_q_reg ? add_sum[caar_pkg::WORD_W-1:0] : shift_reg;
                    done_reg   <= 1'b1;
                    state_reg  <= A_IDLE;
                end
                default:
                begin
                    state_reg <= A_IDLE;
                end
            endcase
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = result_reg;

endmodule

/* rtl/checked_alu_request_responder.sv */
// After the checksum byte, add, subtract, unknown opcode and divide by zero finish
// directly in caar_alu's idle state, while multiply and other divides iterate; a 13-byte
// response then leaves one byte a cycle while tx_stall is low. Input takes one request
// byte a cycle while receiving and the output register is free; it stalls while
// computing and sending. rst_n clears framing and outputs asynchronously.
module checked_alu_request_responder
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] rx_byte,
    input  logic       rx_valid,
    output logic       rx_stall,
    output logic [7:0] tx_byte,
    output logic       status,
    output logic       last,
    output logic       tx_valid,
    input  logic       tx_stall
);

    typedef enum logic [1:0] {
        S_RECV,
        S_CALC,
        S_SEND
    } top_state_t;

    top_state_t                        state_reg;
    logic [caar_pkg::POS_W-1:0]        pos_reg;
    logic [caar_pkg::BYTE_W-1:0]       opcode_reg;
    logic [caar_pkg::WORD_W-1:0]       op_a_reg;
    logic [caar_pkg::WORD_W-1:0]       op_b_reg;
    logic [caar_pkg::BYTE_W-1:0]       xor_reg;
    logic [caar_pkg::RESP_W-1:0]       resp_reg;
    logic [caar_pkg::POS_W-1:0]        send_cnt_reg;
    logic [caar_pkg::BYTE_W-1:0]       tx_byte_reg;
    logic                              status_reg;
    logic                              last_reg;
    logic                              tx_valid_reg;

    logic                              out_free;
    logic                              rx_accept;
    logic                              at_check;
    logic                              sum_ok;
    caar_pkg::alu_req_t                alu_req;
    caar_pkg::alu_rsp_t                alu_rsp;

    // The output register may take a new item when empty or being drained.
    assign out_free  = !tx_valid_reg || !tx_stall;
    assign rx_stall  = !((state_reg == S_RECV) && out_free);
    assign rx_accept = rx_valid && !rx_stall;
    // Any position from the checksum slot up is handled as the checksum byte.
    assign at_check  = (pos_reg >= caar_pkg::POS_W'(caar_pkg::CHECK_POS));
    assign sum_ok    = (rx_byte == xor_reg);

    // Launch the computation as the matching checksum byte is taken.
    assign alu_req.start = rx_accept && at_check && sum_ok;
    assign alu_req.op    = opcode_reg;
    assign alu_req.a     = op_a_reg;
    assign alu_req.b     = op_b_reg;

    caar_alu u_alu
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .rsp   (alu_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_RECV;
            pos_reg      <= '0;
            opcode_reg   <= '0;
            op_a_reg     <= '0;
            op_b_reg     <= '0;
            xor_reg      <= '0;
            resp_reg     <= '0;
            send_cnt_reg <= '0;
            tx_byte_reg  <= '0;
            status_reg   <= 1'b0;
            last_reg     <= 1'b0;
            tx_valid_reg <= 1'b0;
        end
        else
        begin
            // Drop the output item once the consumer takes it.
            if (tx_valid_reg && !tx_stall)
            begin
                tx_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_RECV:
                begin
                    if (rx_accept)
                    begin
                        if (!at_check)
                        begin
                            // Collect the request: opcode, then operands big-endian.
                            if (pos_reg == '0)
                            begin
                                opcode_reg <= rx_byte;
                                xor_reg    <= rx_byte;
                            end
                            else
                            begin
                                xor_reg <= xor_reg ^ rx_byte;
                                if (pos_reg <= caar_pkg::POS_W'(caar_pkg::OPA_LAST))
                                begin
                                    op_a_reg <= {op_a_reg[caar_pkg::WORD_W-9:0], rx_byte};
                                end
                                else
                                begin
                                    op_b_reg <= {op_b_reg[caar_pkg::WORD_W-9:0], rx_byte};
                                end
                            end
                            pos_reg <= pos_reg + 1'b1;
                        end
                        else
                        begin
                            pos_reg <= '0;
                            if (!sum_ok)
                            begin
                                // Checksum mismatch: drop the request, emit one status item.
                                tx_byte_reg  <= '0;
                                status_reg   <= 1'b1;
                                last_reg     <= 1'b1;
                                tx_valid_reg <= 1'b1;
                            end
                            else
                            begin
                                state_reg <= S_CALC;
                            end
                        end
                    end
                end
                S_CALC:
                begin
                    // Hold until the ALU finishes, then stage the whole response.
                    if (alu_rsp.done)
                    begin
                        resp_reg     <= {opcode_reg, op_a_reg, op_b_reg, alu_rsp.result};
                        send_cnt_reg <= '0;
                        state_reg    <= S_SEND;
                    end
                end
                S_SEND:
                begin
                    if (out_free)
                    begin
                        tx_byte_reg  <= resp_reg[caar_pkg::RESP_W-1 -: caar_pkg::BYTE_W];
                        resp_reg     <= {resp_reg[caar_pkg::RESP_W-caar_pkg::BYTE_W-1:0],
                                         caar_pkg::BYTE_W'(0)};
                        status_reg   <= 1'b0;
                        last_reg     <= (send_cnt_reg ==
                                         caar_pkg::POS_W'(caar_pkg::RESP_BYTES - 1));
                        tx_valid_reg <= 1'b1;
                        send_cnt_reg <= send_cnt_reg + 1'b1;
                        if (send_cnt_reg == caar_pkg::POS_W'(caar_pkg::RESP_BYTES - 1))
                        begin
                            state_reg <= S_RECV;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_RECV;
                end
            endcase
        end
    end

    assign tx_byte  = tx_byte_reg;
    assign status   = status_reg;
    assign last     = last_reg;
    assign tx_valid = tx_valid_reg;

endmodule

/* dv/tb_checked_alu_request_responder.sv */
module tb_checked_alu_request_responder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    // Longest path from a checksum byte to its final response byte is the
    // divide plus thirteen output bytes; leave room on top of that.
    localparam int unsigned DRAIN_CYCLES = 80;
    localparam int unsigned HOLDOFF_LEN  = 300;
    localparam logic [caar_pkg::BYTE_W-1:0] OP_UNDEFINED = 8'hA5;

    // One response item as it should appear on the output port.
    typedef struct packed {
        logic [caar_pkg::BYTE_W-1:0] data;
        logic                        err;
        logic                        fin;
    } tx_item_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic [7:0]       rx_byte = 8'h00;
    logic             rx_valid = 1'b0;
    logic             rx_stall;
    logic [7:0]       tx_byte;
    logic             status;
    logic             last;
    logic             tx_valid;
    logic             tx_stall = 1'b0;

    // Mirror of the request framing inside the block.
    logic [caar_pkg::POS_W-1:0]  frame_pos = '0;
    logic [caar_pkg::BYTE_W-1:0] frame_op = '0;
    logic [caar_pkg::WORD_W-1:0] frame_a = '0;
    logic [caar_pkg::WORD_W-1:0] frame_b = '0;
    logic [caar_pkg::BYTE_W-1:0] frame_xor = '0;

    tx_item_t    response_q[$];

    // When set, neither side inserts random gaps.
    bit          steady = 1'b0;
    int unsigned holdoff_request = 0;
    int unsigned holdoff_left = 0;

    int unsigned cycles = 0;
    int unsigned errors = 0;
    int unsigned bytes_sent = 0;
    int unsigned answers_expected = 0;
    int unsigned rejects_expected = 0;
    int unsigned items_checked = 0;

    always #4 clk = ~clk;

    checked_alu_request_responder uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_byte  (rx_byte),
        .rx_valid (rx_valid),
        .rx_stall (rx_stall),
        .tx_byte  (tx_byte),
        .status   (status),
        .last     (last),
        .tx_valid (tx_valid),
        .tx_stall (tx_stall)
    );

    // Signed 32-bit arithmetic as the block defines it; divide goes through
    // 64 bits so the most negative value over minus one wraps naturally.
    function automatic logic [caar_pkg::WORD_W-1:0] alu_result(
        input logic [caar_pkg::BYTE_W-1:0] op,
        input logic [caar_pkg::WORD_W-1:0] a,
        input logic [caar_pkg::WORD_W-1:0] b);
        longint sa;
        longint sb;
        longint quot;
        logic [63:0] prod;
        sa = longint'($signed(a));
        sb = longint'($signed(b));
        case (op)
            caar_pkg::OP_ADD: return a + b;
            caar_pkg::OP_SUB: return a - b;
            caar_pkg::OP_MUL:
            begin
                prod = 64'(a) * 64'(b);
                return prod[caar_pkg::WORD_W-1:0];
            end
            caar_pkg::OP_DIV:
            begin
                if (b == '0)
                    return '0;
                quot = sa / sb;
                return quot[caar_pkg::WORD_W-1:0];
            end
            default: return '0;
        endcase
    endfunction

    // Advance the framing by one accepted byte and queue whatever it produces.
    function automatic void absorb_request_byte(input logic [caar_pkg::BYTE_W-1:0] b);
        logic [3*caar_pkg::WORD_W-1:0] body;
        tx_item_t                      item;
        if (frame_pos < caar_pkg::CHECK_POS)
        begin
            if (frame_pos == 0)
            begin
                frame_op  = b;
                frame_xor = b;
            end
            else
            begin
                frame_xor = frame_xor ^ b;
                if (frame_pos <= caar_pkg::OPA_LAST)
                    frame_a = {frame_a[caar_pkg::WORD_W-caar_pkg::BYTE_W-1:0], b};
                else
                    frame_b = {frame_b[caar_pkg::WORD_W-caar_pkg::BYTE_W-1:0], b};
            end
            frame_pos = frame_pos + 1'b1;
            return;
        end
        frame_pos = '0;
        if (b != frame_xor)
        begin
            item = '{data: '0, err: 1'b1, fin: 1'b1};
            response_q.push_back(item);
            rejects_expected++;
            return;
        end
        item = '{data: frame_op, err: 1'b0, fin: 1'b0};
        response_q.push_back(item);
        body = {frame_a, frame_b, alu_result(frame_op, frame_a, frame_b)};
        for (int i = 0; i < caar_pkg::RESP_BYTES - 1; i++)
        begin
            item.data = body[3*caar_pkg::WORD_W-1-caar_pkg::BYTE_W*i -: caar_pkg::BYTE_W];
            item.fin  = (i == caar_pkg::RESP_BYTES - 2);
            response_q.push_back(item);
        end
        answers_expected++;
    endfunction

    // Offer one item on the request side and hold it until the block takes it.
    // Called and returns at a rising edge.
    task automatic send_byte(input logic [caar_pkg::BYTE_W-1:0] b);
        if (!steady && $urandom_range(0, 99) < 6)
        begin
            rx_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        rx_byte  <= b;
        rx_valid <= 1'b1;
        do
            @(posedge clk);
        while (rx_stall);
        absorb_request_byte(b);
        bytes_sent++;
    endtask

    // Frame a request; a nonzero damage mask spoils the checksum byte.
    task automatic send_request(input logic [caar_pkg::BYTE_W-1:0] op,
                                input logic [caar_pkg::WORD_W-1:0] a,
                                input logic [caar_pkg::WORD_W-1:0] b,
                                input logic [caar_pkg::BYTE_W-1:0] damage);
        logic [9*caar_pkg::BYTE_W-1:0] head;
        logic [caar_pkg::BYTE_W-1:0]   sum;
        head = {op, a, b};
        sum  = '0;
        for (int i = 0; i < caar_pkg::CHECK_POS; i++)
        begin
            sum = sum ^ head[9*caar_pkg::BYTE_W-1-caar_pkg::BYTE_W*i -: caar_pkg::BYTE_W];
            send_byte(head[9*caar_pkg::BYTE_W-1-caar_pkg::BYTE_W*i -: caar_pkg::BYTE_W]);
        end
        send_byte(sum ^ damage);
    endtask

    function automatic logic [caar_pkg::WORD_W-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return caar_pkg::WORD_W'($urandom_range(1, 15));
            5: return -caar_pkg::WORD_W'($urandom_range(1, 15));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [caar_pkg::BYTE_W-1:0] pick_opcode();
        if ($urandom_range(0, 99) >= 88)
            return caar_pkg::BYTE_W'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
            0: return caar_pkg::OP_ADD;
            1: return caar_pkg::OP_SUB;
            2: return caar_pkg::OP_MUL;
            default: return caar_pkg::OP_DIV;
        endcase
    endfunction

    // Receiver: random stalls, a quiet mode, and a long hold-off on request.
    always @(posedge clk)
    begin
        if (holdoff_request != 0)
        begin
            holdoff_left    = holdoff_request;
            holdoff_request = 0;
        end
        if (holdoff_left != 0)
        begin
            tx_stall <= 1'b1;
            holdoff_left--;
        end
        else if (steady)
            tx_stall <= 1'b0;
        else
            tx_stall <= ($urandom_range(0, 99) < 6);
    end

    // Compare every accepted response item against the oldest expectation.
    always @(posedge clk)
    begin
        tx_item_t want;
        if (rst_n && tx_valid && !tx_stall)
        begin
            if (response_q.size() == 0)
            begin
                $error("unexpected item: tx_byte %0h status %0b last %0b",
                       tx_byte, status, last);
                errors++;
            end
            else
            begin
                want = response_q.pop_front();
                items_checked++;
                if (tx_byte !== want.data)
                begin
                    $error("tx_byte: expected %0h, got %0h", want.data, tx_byte);
                    errors++;
                end
                if (status !== want.err)
                begin
                    $error("status: expected %0b, got %0b", want.err, status);
                    errors++;
                end
                if (last !== want.fin)
                begin
                    $error("last: expected %0b, got %0b", want.fin, last);
                    errors++;
                end
            end
        end
    end

    // Watchdog: drop the run if it never finishes.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("checked_alu_request_responder: mismatch");
            $finish;
        end
    end

    // Each operation at its operand extremes, including wrap on add and sub.
    task automatic test_operations();
        send_request(caar_pkg::OP_ADD, 32'h7FFF_FFFF, 32'h0000_0001, '0);
        send_request(caar_pkg::OP_ADD, 32'hFFFF_FFFF, 32'h8000_0000, '0);
        send_request(caar_pkg::OP_SUB, 32'h8000_0000, 32'h0000_0001, '0);
        send_request(caar_pkg::OP_SUB, 32'h0000_0000, 32'h7FFF_FFFF, '0);
        send_request(caar_pkg::OP_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
        send_request(caar_pkg::OP_MUL, 32'h7FFF_FFFF, 32'h8000_0000, '0);
        send_request(caar_pkg::OP_DIV, 32'hFFFF_FFF9, 32'h0000_0002, '0);
        send_request(caar_pkg::OP_DIV, 32'h7FFF_FFFF, 32'hFFFF_FFFF, '0);
    endtask

    // Divide by zero, the one overflowing divide, and opcodes with no meaning.
    task automatic test_special_cases();
        send_request(caar_pkg::OP_DIV, 32'h1234_5678, 32'h0000_0000, '0);
        send_request(caar_pkg::OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF, '0);
        send_request(OP_UNDEFINED, 32'hDEAD_BEEF, 32'h0000_0003, '0);
        send_request(8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
    endtask

    // A bad checksum drops the request; the next one must still frame cleanly.
    task automatic test_checksum_reject();
        send_request(caar_pkg::OP_ADD, 32'h0000_0010, 32'h0000_0020, 8'h01);
        send_request(caar_pkg::OP_MUL, 32'h0000_0007, 32'h0000_0006, 8'h80);
        send_request(caar_pkg::OP_SUB, 32'h0000_0005, 32'h0000_0009, '0);
    endtask

    // Run with no gaps on either side so back-to-back timing is exercised.
    task automatic test_steady_stream();
        steady = 1'b1;
        for (int n = 0; n < 6; n++)
            send_request(pick_opcode(), pick_operand(), pick_operand(), '0);
        steady = 1'b0;
    endtask

    // Hold the output off long enough that the block must refuse input.
    task automatic test_backpressure();
        holdoff_request = HOLDOFF_LEN;
        for (int n = 0; n < 3; n++)
            send_request(pick_opcode(), pick_operand(), pick_operand(), '0);
    endtask

    // Mostly well-formed requests, some with spoiled checksums, some junk.
    task automatic test_random_traffic(input int unsigned count);
        int unsigned pick;
        for (int unsigned n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
                send_request(pick_opcode(), pick_operand(), pick_operand(), '0);
            else if (pick < 90)
                send_request(pick_opcode(), pick_operand(), pick_operand(),
                             caar_pkg::BYTE_W'($urandom_range(1, 255)));
            else
                for (int i = 0; i <= caar_pkg::CHECK_POS; i++)
                    send_byte(caar_pkg::BYTE_W'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_operations();
        test_special_cases();
        test_checksum_reject();
        test_steady_stream();
        test_backpressure();
        test_random_traffic(11);

        rx_valid <= 1'b0;
        // Let every expected item come out, then watch for strays.
        while (response_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d request bytes: %0d answered requests, %0d checksum rejects,",
                 bytes_sent, answers_expected, rejects_expected);
        $display("  %0d response items compared, %0d field errors.", items_checked, errors);
        if (errors == 0 && response_q.size() == 0)
            $display("checked_alu_request_responder: match");
        else
            $display("checked_alu_request_responder: mismatch");
        $finish;
    end

endmodule

/* filelist.f */
rtl/caar_pkg.sv
rtl/caar_alu.sv
rtl/checked_alu_request_responder.sv
dv/tb_checked_alu_request_responder.sv
